// ===== hw/rtl/dtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dtp_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int FOCAL_W = 16;
  localparam int BASE_W  = 20;
  localparam int SIZE_W  = 13;
  localparam int DISP_W  = 16;
  localparam int PIX_W   = 12;
  localparam int OUT_W   = 24;

  localparam int MAG_W   = 16;  // |disparity| up to 32768
  localparam int OFF_W   = 12;  // |offset| up to 4095
  localparam int NUM_W   = 38;  // 2*num + den
  localparam int DEN_W   = 26;  // 2*den
  localparam int Q_W     = 24;  // quotient bits resolved by the divider
  localparam int CMP_W   = NUM_W + Q_W;

  localparam logic [FOCAL_W-1:0] FOCAL_RST  = 16'd6515;
  localparam logic [BASE_W-1:0]  BASE_RST   = 20'd30000;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd768;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd493;

  localparam logic [OUT_W-1:0] Z_MAX   = 24'hFFFFFF;
  localparam logic [OUT_W-1:0] POS_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] NEG_MAX = 24'h800000;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;   // 0: x, 1: y, 2: z
    logic        neg_x;
    logic        neg_y;
    logic        invalid;
    logic        fe;
  } div_stage_t;

endpackage
`default_nettype wire

// ===== hw/rtl/disparity_to_point_xyz_core.sv =====
// disparity_to_point_xyz_core
// Reprojects a stream of disparity pixels into 3D points in millimetres.
// in_ channel: one beat per pixel, tdata = {pixel_col, pixel_row, disparity_q4},
// tlast = frame end marker. out_ channel: one beat per pixel, tdata =
// {z, y, x}, tuser = invalid flag (zero disparity), tlast = frame end copy.
// cfg_ port: write enable, register index and data; write only while idle.
// Throughput: one pixel per cycle unless the receiver stalls.
// Pipeline: 28 register stages: magnitude/offset register, multiply stage,
// rounding setup stage, a 24-stage restoring divider (one quotient bit per
// stage, three lanes in parallel for x, y and z) and an output register
// that saturates and applies the sign.
// Each stage has its own valid bit and moves when the next one is empty or
// moving, so bubbles are squeezed out while the receiver stalls and the
// input keeps being accepted until the pipeline is full.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// registers with focal 6515 (Q4), baseline 30000 um, image 768 x 493.
`timescale 1ns / 1ps
`default_nettype none
module disparity_to_point_xyz_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dtp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // disparity_q4[15:0], pixel_row[27:16], pixel_col[39:28]
  input  wire logic [39:0]                      in_tdata,
  input  wire logic                             in_tlast,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // point_x_mm[23:0], point_y_mm[47:24], point_z_mm[71:48]
  output      logic [71:0]                      out_tdata,
  // point_invalid[0]
  output      logic                             out_tuser,
  output      logic                             out_tlast
);
  import dtp_pkg::*;

  localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((1 << COORD_BITS) - 1);

  logic [FOCAL_W-1:0] focal_r;
  logic [BASE_W-1:0]  base_r;
  logic [SIZE_W-1:0]  width_r;
  logic [SIZE_W-1:0]  height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= FOCAL_RST;
      base_r   <= BASE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL:  focal_r  <= cfg_data[FOCAL_W-1:0];
        REG_BASE:   base_r   <= cfg_data[BASE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- valid / ready chain ----------------
  logic             v0_r, v1_r, v2_r, vo_r;
  logic [Q_W-1:0]   dv_r;
  logic             rdy0, rdy1, rdy2, rdyo;
  logic [Q_W-1:0]   rdyd;

  always_comb begin
    rdyo = !vo_r || out_tready;
    for (int j = Q_W - 1; j >= 0; j--) begin
      if (j == Q_W - 1) rdyd[j] = !dv_r[j] || rdyo;
      else              rdyd[j] = !dv_r[j] || rdyd[j+1];
    end
    rdy2 = !v2_r || rdyd[0];
    rdy1 = !v1_r || rdy2;
    rdy0 = !v0_r || rdy1;
  end

  assign in_tready = rdy0;

  // ---------------- stage 0: magnitudes and offsets ----------------
  logic [MAG_W-1:0] mag_r;
  logic             xneg_r, yneg_r, inv0_r, fe0_r;
  logic [OFF_W-1:0] xmag_r, ymag_r;

  logic [DISP_W-1:0] draw;
  logic [PIX_W-1:0]  row, col;
  logic [SIZE_W:0]   xoff, yoff;

  always_comb begin
    draw = in_tdata[15:0];
    row  = in_tdata[27:16] & COORD_MASK;
    col  = in_tdata[39:28] & COORD_MASK;
    xoff = {2'b00, col} - {2'b00, width_r[SIZE_W-1:1]};
    yoff = {2'b00, height_r[SIZE_W-1:1]} - {2'b00, row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (rdy0) v0_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      mag_r  <= draw[DISP_W-1] ? MAG_W'(-draw) : draw;
      inv0_r <= (draw == '0);
      fe0_r  <= in_tlast;
      xneg_r <= xoff[SIZE_W];
      yneg_r <= yoff[SIZE_W];
      xmag_r <= xoff[SIZE_W] ? OFF_W'(-xoff) : xoff[OFF_W-1:0];
      ymag_r <= yoff[SIZE_W] ? OFF_W'(-yoff) : yoff[OFF_W-1:0];
    end
  end

  // ---------------- stage 1: products ----------------
  logic [35:0] zn_r, xn_r, yn_r;
  logic [24:0] den_r;
  logic        xneg1_r, yneg1_r, inv1_r, fe1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (rdy1) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      zn_r    <= 36'(focal_r) * 36'(base_r);
      xn_r    <= {32'(base_r) * 32'(xmag_r), 4'b0000};
      yn_r    <= {32'(base_r) * 32'(ymag_r), 4'b0000};
      den_r   <= 25'(mag_r) * 25'd1000;
      xneg1_r <= xneg_r;
      yneg1_r <= yneg_r;
      inv1_r  <= inv0_r;
      fe1_r   <= fe0_r;
    end
  end

  // ---------------- stage 2: rounding offset and range check ----------------
  div_stage_t s2_r;
  div_stage_t s2_nxt;
  logic [35:0] nums [3];

  always_comb begin
    nums[0] = xn_r;
    nums[1] = yn_r;
    nums[2] = zn_r;
    for (int l = 0; l < 3; l++) begin
      s2_nxt.lane[l].rem = {1'b0, nums[l], 1'b0} + NUM_W'(den_r);
      s2_nxt.lane[l].den = {den_r, 1'b0};
      s2_nxt.lane[l].quo = '0;
      // quotient needs more than Q_W bits: clamp later
      s2_nxt.lane[l].ovf = CMP_W'(s2_nxt.lane[l].rem) >=
                           (CMP_W'(s2_nxt.lane[l].den) << Q_W);
    end
    s2_nxt.neg_x   = xneg1_r;
    s2_nxt.neg_y   = yneg1_r;
    s2_nxt.invalid = inv1_r;
    s2_nxt.fe      = fe1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (rdy2) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2) s2_r <= s2_nxt;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  div_stage_t dp_r   [Q_W];
  div_stage_t dp_nxt [Q_W];
  logic       dvi    [Q_W];

  always_comb begin
    logic [CMP_W-1:0] sh;
    for (int j = 0; j < Q_W; j++) begin
      dp_nxt[j] = (j == 0) ? s2_r : dp_r[(j == 0) ? 0 : j - 1];
      dvi[j]    = (j == 0) ? v2_r : dv_r[(j == 0) ? 0 : j - 1];
      for (int l = 0; l < 3; l++) begin
        sh = CMP_W'(dp_nxt[j].lane[l].den) << (Q_W - 1 - j);
        if (CMP_W'(dp_nxt[j].lane[l].rem) >= sh) begin
          dp_nxt[j].lane[l].rem = dp_nxt[j].lane[l].rem - sh[NUM_W-1:0];
          dp_nxt[j].lane[l].quo[Q_W-1-j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else begin
      for (int j = 0; j < Q_W; j++) begin
        if (rdyd[j]) dv_r[j] <= dvi[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Q_W; j++) begin
      if (rdyd[j]) dp_r[j] <= dp_nxt[j];
    end
  end

  // ---------------- output: saturate and sign ----------------
  div_stage_t fin;
  logic [OUT_W-1:0] x_nxt, y_nxt, z_nxt;
  logic [OUT_W-1:0] lat_q [2];
  logic [OUT_W-1:0] lat_o [2];
  logic             lat_n [2];

  always_comb begin
    fin      = dp_r[Q_W-1];
    lat_n[0] = fin.neg_x;
    lat_n[1] = fin.neg_y;
    for (int l = 0; l < 2; l++) begin
      lat_q[l] = fin.lane[l].quo;
      if (lat_n[l]) begin
        if (fin.lane[l].ovf || lat_q[l] > NEG_MAX) lat_o[l] = NEG_MAX;
        else lat_o[l] = OUT_W'(-lat_q[l]);
      end else begin
        if (fin.lane[l].ovf || lat_q[l] > POS_MAX) lat_o[l] = POS_MAX;
        else lat_o[l] = lat_q[l];
      end
    end
    if (fin.invalid) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = Z_MAX;
    end else begin
      x_nxt = lat_o[0];
      y_nxt = lat_o[1];
      z_nxt = fin.lane[2].ovf ? Z_MAX : fin.lane[2].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (rdyo) vo_r <= dv_r[Q_W-1];
  end

  always_ff @(posedge clk) begin
    if (rdyo) begin
      out_tdata <= {z_nxt, y_nxt, x_nxt};
      out_tuser <= fin.invalid;
      out_tlast <= fin.fe;
    end
  end

  assign out_tvalid = vo_r;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import dtp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  disparity_to_point_xyz_core u_top (.*);

  always #4 clk = ~clk;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        invalid;
    logic        fe;
  } point_t;

  point_t pending_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  logic [15:0] focal;
  logic [19:0] base;
  logic [12:0] img_w;
  logic [12:0] img_h;

  function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [23:0] lateral_mm(longint off, logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (off < 0) ? -off : off;
    q = round_div(64'd16 * 64'(base) * mag, den);
    if (off < 0) begin
      if (q > 64'd8388608) q = 64'd8388608;
      return 24'(-q);
    end
    if (q > 64'd8388607) q = 64'd8388607;
    return q[23:0];
  endfunction

  function automatic point_t reproject(logic [15:0] disp, logic [11:0] row,
                                       logic [11:0] col, logic fe);
    point_t p;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] z;
    mag = disp[15] ? (64'h10000 - 64'(disp)) : 64'(disp);
    p.fe = fe;
    if (mag == 0) begin
      p.x = '0; p.y = '0; p.z = Z_MAX; p.invalid = 1'b1;
      return p;
    end
    den = mag * 64'd1000;
    z = round_div(64'(focal) * 64'(base), den);
    if (z > 64'hFFFFFF) z = 64'hFFFFFF;
    p.z = z[23:0];
    p.x = lateral_mm(longint'(col) - longint'(img_w >> 1), den);
    p.y = lateral_mm(longint'(img_h >> 1) - longint'(row), den);
    p.invalid = 1'b0;
    return p;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCAL:  focal = val[15:0];
      REG_BASE:   base = val[19:0];
      REG_WIDTH:  img_w = val[12:0];
      REG_HEIGHT: img_h = val[12:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(logic [15:0] disp, logic [11:0] row, logic [11:0] col,
                            logic fe);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {col, row, disp};
    in_tlast <= fe;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_points = {pending_points, reproject(disp, row, col, fe)};
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    end_burst();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    point_t exp_p;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected beat x=%h y=%h z=%h", out_tdata[23:0], out_tdata[47:24],
               out_tdata[71:48]);
        errors++;
      end else begin
        exp_p = pending_points.pop_front();
        if (out_tdata[23:0] !== exp_p.x) begin
          $error("point_x_mm exp %h got %h", exp_p.x, out_tdata[23:0]); errors++;
        end
        if (out_tdata[47:24] !== exp_p.y) begin
          $error("point_y_mm exp %h got %h", exp_p.y, out_tdata[47:24]); errors++;
        end
        if (out_tdata[71:48] !== exp_p.z) begin
          $error("point_z_mm exp %h got %h", exp_p.z, out_tdata[71:48]); errors++;
        end
        if (out_tuser !== exp_p.invalid) begin
          $error("point_invalid exp %b got %b", exp_p.invalid, out_tuser); errors++;
        end
        if (out_tlast !== exp_p.fe) begin
          $error("frame_end_out exp %b got %b", exp_p.fe, out_tlast); errors++;
        end
      end
    end
    if (recv_hold) out_tready <= 1'b0;
    else out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  task automatic random_pixels(int n);
    logic [15:0] d;
    repeat (n) begin
      case ($urandom_range(9))
        0: d = '0;
        1: d = 16'($urandom_range(1, 16));
        2: d = 16'(-$urandom_range(1, 16));
        3: d = 16'h8000;
        default: d = 16'($urandom());
      endcase
      send_pixel(d, 12'($urandom()), 12'($urandom()), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_directed();
    send_pixel(16'd0, 12'd0, 12'd0, 1'b0);
    send_pixel(16'hFFFF, 12'd0, 12'd0, 1'b1);
    send_pixel(16'h0001, 12'd4095, 12'd4095, 1'b0);
    send_pixel(16'h8000, 12'd4095, 12'd0, 1'b1);
    send_pixel(16'h7FFF, 12'd246, 12'd384, 1'b0);
    send_pixel(16'h0010, 12'd246, 12'd384, 1'b0);
    send_pixel(16'hFFF0, 12'd100, 12'd700, 1'b0);
    send_pixel(16'h0003, 12'd0, 12'd4095, 1'b1);
    send_pixel(16'd640, 12'd2048, 12'd2048, 1'b0);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_FOCAL, 20'd65535);
    write_reg(REG_BASE, 20'hFFFFF);
    write_reg(REG_WIDTH, 20'd1);
    write_reg(REG_HEIGHT, 20'd4096);
    send_pixel(16'h0001, 12'd0, 12'd4095, 1'b0);
    send_pixel(16'hFFFF, 12'd4095, 12'd0, 1'b1);
    send_pixel(16'h8000, 12'd2048, 12'd1, 1'b0);
    drain();
    // zero and out-of-range register values take the low bits
    write_reg(REG_FOCAL, 20'd0);
    write_reg(REG_BASE, 20'd0);
    write_reg(REG_WIDTH, 20'h1FFFF);
    write_reg(REG_HEIGHT, 20'd0);
    send_pixel(16'h0005, 12'd9, 12'd9, 1'b0);
    send_pixel(16'h0000, 12'd9, 12'd9, 1'b0);
    drain();
    write_reg(REG_FOCAL, 20'd1);
    write_reg(REG_BASE, 20'd1);
    write_reg(REG_WIDTH, 20'd8191);
    write_reg(REG_HEIGHT, 20'd8191);
    send_pixel(16'h0001, 12'd0, 12'd0, 1'b1);
    random_pixels(20);
    drain();
  endtask

  task automatic test_random_phases();
    int i;
    for (i = 0; i < 4; i++) begin
      write_reg(REG_FOCAL, 20'($urandom_range(1, 65535)));
      write_reg(REG_BASE, (i == 0) ? 20'd30000 : 20'($urandom_range(1, 1048575)));
      write_reg(REG_WIDTH, 20'($urandom_range(1, 4096)));
      write_reg(REG_HEIGHT, 20'($urandom_range(1, 4096)));
      case (i)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      random_pixels(350);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk);
        recv_hold = 1'b0;
      end
      random_pixels(100);
    join
    drain();
  endtask

  initial begin
    focal = FOCAL_RST;
    base = BASE_RST;
    img_w = WIDTH_RST;
    img_h = HEIGHT_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== disparity_to_point_xyz_core.f =====
hw/rtl/dtp_pkg.sv
hw/rtl/disparity_to_point_xyz_core.sv
bench/testbench.sv
